// ===== src/rcst_pkg.sv =====
// ----------------------------------------------------------------------------
// rcst_pkg
// Shared widths, codes and register map of the range combine segment tree.
// ----------------------------------------------------------------------------
package rcst_pkg;

  // Tree capacity and the widths that follow from it.
  localparam int MAX_LEAVES = 1024;
  localparam int NODE_DEPTH = 2 * MAX_LEAVES;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int BOUND_W    = NODE_AW + 1;

  // Field widths.
  localparam int VALUE_W      = 64;
  localparam int INDEX_W      = 10;
  localparam int LEAF_COUNT_W = 11;

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  localparam logic [1:0] REG_LEAF_COUNT   = 2'd0;
  localparam logic [1:0] REG_COMBINE_MODE = 2'd1;
  localparam logic [1:0] REG_IDENTITY     = 2'd2;

  localparam logic MODE_SUM = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

endpackage

// ===== src/rcst_combine.sv =====
// ----------------------------------------------------------------------------
// rcst_combine
// The shared combine unit: wrapping 64-bit sum or signed 64-bit maximum.
// ----------------------------------------------------------------------------
module rcst_combine (
  input  logic                        mode,
  input  logic [rcst_pkg::VALUE_W-1:0] a,
  input  logic [rcst_pkg::VALUE_W-1:0] b,
  output logic [rcst_pkg::VALUE_W-1:0] y
);
  import rcst_pkg::*;

  logic [VALUE_W-1:0] sum;
  logic               a_wins;

  assign sum    = a + b;
  // On a tie the left operand is kept.
  assign a_wins = $signed(a) >= $signed(b);

  always_comb begin
    case (mode)
      MODE_MAX: y = a_wins ? a : b;
      default:  y = sum;
    endcase
  end

endmodule

// ===== src/range_combine_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_combine_segment_tree
// Bottom-up segment tree with point update and inclusive range query.
// ----------------------------------------------------------------------------
// The tree lives in one 2048 x 64 memory with one write port and two
// registered read ports, and every combine goes through a single shared
// sum/max unit. An update walks up the tree one level at a time: it writes
// the node and reads its sibling, then combines. The block takes no new
// request until the update is through, and an update with a good index
// produces no result. A query also walks up one level at a time: it reads
// the boundary nodes, then does one combine for each side that needs it;
// a final combine and the result state follow. Bad indexes and empty
// ranges go straight to the result state, and the block is ready again
// once the response is loaded. After reset, and after every write of
// leaf_count, a clearing pass writes the identity value into all 2048
// entries, one per cycle; the block takes no request while it runs.
module range_combine_segment_tree (
  input  logic                                   clk,
  input  logic                                   rst,
  // Request channel.
  input  logic                                   req_valid,
  output logic                                   req_ready,
  input  logic                                   cmd,
  input  logic [rcst_pkg::INDEX_W-1:0]           first_index,
  input  logic [rcst_pkg::INDEX_W-1:0]           last_index,
  input  logic signed [rcst_pkg::VALUE_W-1:0]    new_value,
  // Response channel.
  output logic                                   rsp_valid,
  input  logic                                   rsp_ready,
  output logic signed [rcst_pkg::VALUE_W-1:0]    range_value,
  output logic                                   index_error,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rcst_pkg::PADDR_W-1:0]           paddr,
  input  logic [rcst_pkg::PDATA_W-1:0]           pwdata,
  output logic [rcst_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);
  import rcst_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UWRITE = 3'd1;
  localparam logic [2:0] S_UCOMB  = 3'd2;
  localparam logic [2:0] S_QREAD  = 3'd3;
  localparam logic [2:0] S_QLEFT  = 3'd4;
  localparam logic [2:0] S_QRIGHT = 3'd5;
  localparam logic [2:0] S_QFINAL = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  // Configuration registers.
  logic [LEAF_COUNT_W-1:0] leaf_count;
  logic                    combine_mode;
  logic [VALUE_W-1:0]      identity_value;

  // Control.
  logic [2:0]         state;
  logic               fill_active;
  logic [NODE_AW-1:0] fill_addr;
  logic [VALUE_W-1:0] fill_value;

  // Datapath.
  logic [NODE_AW-1:0] upd_node;
  logic [BOUND_W-1:0] q_l;
  logic [BOUND_W-1:0] q_r;
  logic [VALUE_W-1:0] cur;
  logic [VALUE_W-1:0] acc_left;
  logic [VALUE_W-1:0] acc_right;
  logic [VALUE_W-1:0] res_value;
  logic               res_error;

  // Node memory.
  logic [VALUE_W-1:0] node_mem [NODE_DEPTH];
  logic               mem_we;
  logic [NODE_AW-1:0] mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [NODE_AW-1:0] mem_raddr_a;
  logic [NODE_AW-1:0] mem_raddr_b;
  logic [VALUE_W-1:0] rd_a;
  logic [VALUE_W-1:0] rd_b;

  // Combine unit operands.
  logic [VALUE_W-1:0] op_a;
  logic [VALUE_W-1:0] op_b;
  logic [VALUE_W-1:0] op_y;

  logic                    cfg_write;
  logic [1:0]              cfg_reg;
  logic [LEAF_COUNT_W-1:0] lc_raw;
  logic [LEAF_COUNT_W-1:0] lc_clamped;
  logic                    req_xfer;
  logic                    rsp_free;
  logic [LEAF_COUNT_W-1:0] first_ext;
  logic [LEAF_COUNT_W-1:0] last_ext;
  logic                    first_bad;
  logic                    last_bad;
  logic [BOUND_W-1:0]      q_l_adv;
  logic [BOUND_W-1:0]      q_r_adv;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_reg   = paddr[PADDR_W-1:3];
  assign lc_raw    = pwdata[LEAF_COUNT_W-1:0];

  always_comb begin
    if (lc_raw == '0) begin
      lc_clamped = LEAF_COUNT_W'(1);
    end else if (lc_raw > LEAF_COUNT_W'(MAX_LEAVES)) begin
      lc_clamped = LEAF_COUNT_W'(MAX_LEAVES);
    end else begin
      lc_clamped = lc_raw;
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_LEAF_COUNT:   prdata = PDATA_W'(leaf_count);
      REG_COMBINE_MODE: prdata = PDATA_W'(combine_mode);
      REG_IDENTITY:     prdata = PDATA_W'(identity_value);
      default:          prdata = '0;
    endcase
  end

  assign req_ready = (state == S_IDLE) && !fill_active;
  assign req_xfer  = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign first_ext = LEAF_COUNT_W'(first_index);
  assign last_ext  = LEAF_COUNT_W'(last_index);
  assign first_bad = first_ext >= leaf_count;
  assign last_bad  = last_ext >= leaf_count;

  // One level up the query walk: an odd left bound has been consumed and
  // moves right, an odd right bound has been consumed and moves left.
  assign q_l_adv = (q_l + BOUND_W'(q_l[0])) >> 1;
  assign q_r_adv = (q_r - BOUND_W'(q_r[0])) >> 1;

  // Operand selection for the shared combine unit.
  always_comb begin
    unique case (state)
      S_UCOMB: begin
        op_a = upd_node[0] ? rd_a : cur;
        op_b = upd_node[0] ? cur : rd_a;
      end
      S_QLEFT: begin
        op_a = acc_left;
        op_b = rd_a;
      end
      S_QRIGHT: begin
        op_a = rd_b;
        op_b = acc_right;
      end
      S_QFINAL: begin
        op_a = acc_left;
        op_b = acc_right;
      end
      default: begin
        op_a = cur;
        op_b = rd_a;
      end
    endcase
  end

  rcst_combine u_combine (
    .mode (combine_mode),
    .a    (op_a),
    .b    (op_b),
    .y    (op_y)
  );

  // Memory port control. The clearing pass owns the write port while it runs.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = upd_node;
    mem_wdata   = cur;
    mem_re      = 1'b0;
    mem_raddr_a = upd_node ^ NODE_AW'(1);
    mem_raddr_b = NODE_AW'(q_r - BOUND_W'(1));
    if (fill_active) begin
      mem_we    = 1'b1;
      mem_waddr = fill_addr;
      mem_wdata = fill_value;
    end else if (state == S_UWRITE) begin
      mem_we = 1'b1;
      mem_re = 1'b1;
    end
    if (state == S_QREAD) begin
      mem_re      = 1'b1;
      mem_raddr_a = NODE_AW'(q_l);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_a <= node_mem[mem_raddr_a];
      rd_b <= node_mem[mem_raddr_b];
    end
  end

  // Control state, configuration and the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      leaf_count     <= LEAF_COUNT_W'(MAX_LEAVES);
      combine_mode   <= MODE_SUM;
      identity_value <= '0;
      fill_active    <= 1'b1;
      fill_addr      <= '0;
      fill_value     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      // A leaf_count write restarts the pass below, so it takes precedence.
      if (fill_active && !(cfg_write && (cfg_reg == REG_LEAF_COUNT))) begin
        fill_addr <= fill_addr + NODE_AW'(1);
        if (fill_addr == NODE_AW'(NODE_DEPTH - 1)) begin
          fill_active <= 1'b0;
        end
      end

      if (cfg_write) begin
        unique case (cfg_reg)
          REG_LEAF_COUNT: begin
            leaf_count  <= lc_clamped;
            fill_active <= 1'b1;
            fill_addr   <= '0;
            fill_value  <= identity_value;
          end
          REG_COMBINE_MODE: combine_mode   <= pwdata[0];
          REG_IDENTITY:     identity_value <= pwdata[VALUE_W-1:0];
          default: ;
        endcase
      end

      if (state == S_EMIT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            if (cmd == CMD_UPDATE) begin
              state <= first_bad ? S_EMIT : S_UWRITE;
            end else if (first_bad || last_bad || (first_index > last_index)) begin
              state <= S_EMIT;
            end else begin
              state <= S_QREAD;
            end
          end
        end
        S_UWRITE: begin
          state <= (upd_node == NODE_AW'(1)) ? S_IDLE : S_UCOMB;
        end
        S_UCOMB: state <= S_UWRITE;
        S_QREAD: begin
          if (q_l >= q_r) begin
            state <= S_QFINAL;
          end else if (q_l[0]) begin
            state <= S_QLEFT;
          end else if (q_r[0]) begin
            state <= S_QRIGHT;
          end
        end
        S_QLEFT:  state <= q_r[0] ? S_QRIGHT : S_QREAD;
        S_QRIGHT: state <= S_QREAD;
        S_QFINAL: state <= S_EMIT;
        S_EMIT: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur       <= new_value;
        upd_node  <= NODE_AW'(first_ext + leaf_count);
        q_l       <= BOUND_W'(first_ext) + BOUND_W'(leaf_count);
        q_r       <= BOUND_W'(last_ext) + BOUND_W'(leaf_count) + BOUND_W'(1);
        acc_left  <= identity_value;
        acc_right <= identity_value;
        res_value <= identity_value;
        res_error <= (cmd == CMD_UPDATE) ? first_bad : (first_bad || last_bad);
      end
      S_UCOMB: begin
        cur      <= op_y;
        upd_node <= upd_node >> 1;
      end
      S_QREAD: begin
        if (q_l < q_r && !q_l[0] && !q_r[0]) begin
          q_l <= q_l_adv;
          q_r <= q_r_adv;
        end
      end
      S_QLEFT: begin
        acc_left <= op_y;
        if (!q_r[0]) begin
          q_l <= q_l_adv;
          q_r <= q_r_adv;
        end
      end
      S_QRIGHT: begin
        acc_right <= op_y;
        q_l       <= q_l_adv;
        q_r       <= q_r_adv;
      end
      S_QFINAL: begin
        res_value <= op_y;
        res_error <= 1'b0;
      end
      default: ;
    endcase

    if (state == S_EMIT && rsp_free) begin
      range_value <= res_value;
      index_error <= res_error;
    end
  end

endmodule

// ===== src/rcst_check.sv =====
// ----------------------------------------------------------------------------
// rcst_check
// Port-level checks of the range combine segment tree, bound to the top.
// ----------------------------------------------------------------------------
module rcst_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [rcst_pkg::VALUE_W-1:0] range_value,
  input logic                                index_error,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic                                pready,
  input logic [rcst_pkg::PADDR_W-1:0]        paddr
);
  import rcst_pkg::*;

  // A stalled response keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(range_value) && $stable(index_error))
    else $error("response changed while stalled");

  // One request at a time: the block is busy right after a transfer.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is in flight");

  // Writing leaf_count starts the clearing pass, which blocks requests.
  a_fill_blocks: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[PADDR_W-1:3] == REG_LEAF_COUNT)
    |=> !req_ready)
    else $error("request accepted during the clearing pass");

  // Reset empties the response slot and starts the clearing pass.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("block not quiet after reset");

endmodule

bind range_combine_segment_tree rcst_check u_rcst_check (.*);
